/* rtl/core/sobel_energy_map_core_assert.svh */
// assertion helpers, clocked on clk, quiet while arst_n is low
`ifndef SOBEL_ENERGY_MAP_CORE_ASSERT_SVH
`define SOBEL_ENERGY_MAP_CORE_ASSERT_SVH

`define SEM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sem_pkg.sv */
package sem_pkg;
	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 4096;
	localparam int MAX_CHANNELS = 4;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WCFG_W = 12;
	localparam int HCFG_W = 13;
	localparam int NCFG_W = 3;
	localparam int MAG_W  = 15;
	localparam int SUM_W  = 17;
	localparam int ROOT_STEPS = 16;
	localparam logic [16:0] RECIP3 = 17'd43691;  // ceil(2^17/3)

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;

	typedef struct packed {
		logic start;
		logic step;
	} lane_ctl_t;

	typedef struct packed {
		logic sum_en;
		logic div_en;
	} merge_ctl_t;

	// [column][row] of 8-bit samples for one channel
	typedef logic [2:0][2:0][7:0] nbr_t;
endpackage

/* rtl/core/sem_lane.sv */
module sem_lane import sem_pkg::*; (
	input  logic              clk,
	input  lane_ctl_t         ctl,
	input  nbr_t              nbr,
	output logic [MAG_W-1:0]  mag
);
	logic signed [10:0] gx, gy;
	logic signed [21:0] sq;
	logic [28:0] v_q;
	logic [30:0] res_q, bit_q, trial;

	always_comb begin
		gx = (11'(nbr[2][0]) + 11'(nbr[2][1]) * 11'sd2 + 11'(nbr[2][2]))
		   - (11'(nbr[0][0]) + 11'(nbr[0][1]) * 11'sd2 + 11'(nbr[0][2]));
		gy = (11'(nbr[0][2]) + 11'(nbr[1][2]) * 11'sd2 + 11'(nbr[2][2]))
		   - (11'(nbr[0][0]) + 11'(nbr[1][0]) * 11'sd2 + 11'(nbr[2][0]));
		sq = 22'(gx * gx) + 22'(gy * gy);
		trial = res_q + bit_q;
	end

	// bit-pair square root, one step per cycle while ctl.step is high
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q   <= {sq[20:0], 8'd0};
			res_q <= '0;
			bit_q <= 31'h4000_0000;
		end else if (ctl.step) begin
			if ({2'b0, v_q} >= trial) begin
				v_q   <= 29'({2'b0, v_q} - trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign mag = res_q[MAG_W-1:0];
endmodule

/* rtl/core/sem_merge.sv */
module sem_merge import sem_pkg::*; (
	input  logic                                clk,
	input  merge_ctl_t                          ctl,
	input  logic [MAX_CHANNELS-1:0][MAG_W-1:0]  mag,
	input  logic [NCFG_W-1:0]                   n,
	output logic [MAG_W-1:0]                    energy
);
	logic [SUM_W-1:0] sum_c, sum_s1;
	logic [SUM_W+16:0] prod;
	logic [MAG_W-1:0] q;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_CHANNELS; i++)
			if (NCFG_W'(i) < n)
				sum_c = sum_c + SUM_W'(mag[i]);
		prod = 34'(sum_s1) * 34'(RECIP3);
		case (n)
			3'd1:    q = MAG_W'(sum_s1);
			3'd2:    q = MAG_W'(sum_s1 >> 1);
			3'd3:    q = MAG_W'(prod >> 17);
			default: q = MAG_W'(sum_s1 >> 2);
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en)
			sum_s1 <= sum_c;
		if (ctl.div_en)
			energy <= q;
	end
endmodule

/* rtl/core/sobel_energy_map_core.sv */
// Flow: an accepted pixel passes read and pick; each of its results then passes load, the
//   root steps, sum, divide and output. A pixel with no result goes back to idle after pick.
//   No new pixel is taken until the last is done; the square-root step loop in the lanes takes most of that time.
// Reset: async arst_n clears counters, window and control; config goes to
//   640x480, 3 channels. Line buffers are not cleared.
module sobel_energy_map_core import sem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        chan0,
	input  logic [7:0]        chan1,
	input  logic [7:0]        chan2,
	input  logic [7:0]        chan3,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROW_W-1:0]  pix_row,
	output logic [COL_W-1:0]  pix_col,
	output logic [MAG_W-1:0]  energy,
	output logic              run_end,
	output logic              image_end,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [HCFG_W-1:0] cfg_data
);
	`include "sobel_energy_map_core_assert.svh"

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_READ = 8'b0000_0010,
		S_PICK = 8'b0000_0100,
		S_LOAD = 8'b0000_1000,
		S_ROOT = 8'b0001_0000,
		S_SUM  = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [WCFG_W-1:0] width_q, w;
	logic [HCFG_W-1:0] height_q, h;
	logic [NCFG_W-1:0] chans_q, n;
	logic [ROW_W-1:0] row_q, ir_q;
	logic [COL_W-1:0] col_q, ic_q;
	logic [31:0] pix_q;
	logic [63:0] rd_q;
	logic [63:0] line_mem [MAX_WIDTH];
	logic [2:0][2:0][31:0] win_q;
	logic [3:0] slots_q, cur_slot_q, pick;
	logic [3:0] iter_q;
	logic last_row, last_col, in_acc, out_acc;
	logic [1:0] csel [3];
	logic [1:0] rsel [3];
	nbr_t nbr [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0][MAG_W-1:0] mag;
	lane_ctl_t lctl;
	merge_ctl_t mctl;

	always_comb begin
		w = (width_q < 12'd2) ? 12'd2 : (width_q > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_q;
		h = (height_q < 13'd2) ? 13'd2
		  : (height_q > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : height_q;
		n = (chans_q == 3'd0) ? 3'd1 : (chans_q > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chans_q;
		last_row = ({1'b0, ir_q} == h - 13'd1);
		last_col = ({1'b0, ic_q} == w - 12'd1);
		// a pending register write goes ahead of pixels
		in_stall = (state_q != S_IDLE) || cfg_valid;
		cfg_ready = (state_q == S_IDLE);
		in_acc = in_valid && !in_stall;
		out_valid = (state_q == S_OUT);
		out_acc = out_valid && !out_stall;
		pick = slots_q & (~slots_q + 4'd1);
		// slots 0,1 center on column c-1; slots 2,3 on the last column
		csel[0] = (cur_slot_q[2] || cur_slot_q[3]) ? 2'd1 : ((ic_q == 11'd1) ? 2'd1 : 2'd0);
		csel[1] = (cur_slot_q[2] || cur_slot_q[3]) ? 2'd2 : 2'd1;
		csel[2] = 2'd2;
		// slots 1,3 center on the last row itself
		rsel[0] = (cur_slot_q[1] || cur_slot_q[3]) ? 2'd1 : ((ir_q == 12'd1) ? 2'd1 : 2'd0);
		rsel[1] = (cur_slot_q[1] || cur_slot_q[3]) ? 2'd2 : 2'd1;
		rsel[2] = 2'd2;
		for (int k = 0; k < MAX_CHANNELS; k++)
			for (int x = 0; x < 3; x++)
				for (int y = 0; y < 3; y++)
					nbr[k][x][y] = win_q[csel[x]][rsel[y]][8*k +: 8];
		lctl.start = (state_q == S_LOAD);
		lctl.step = (state_q == S_ROOT);
		mctl.sum_en = (state_q == S_SUM);
		mctl.div_en = (state_q == S_DIV);
		pix_row = (cur_slot_q[1] || cur_slot_q[3]) ? ir_q : ir_q - 12'd1;
		pix_col = (cur_slot_q[0] || cur_slot_q[1]) ? ic_q - 11'd1 : ic_q;
		run_end = ((slots_q & ~cur_slot_q) == 4'd0);
		image_end = cur_slot_q[3];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= line_mem[col_q];
			pix_q <= {chan3, chan2, chan1, chan0};
		end
		if (state_q == S_READ)
			line_mem[ic_q] <= {rd_q[31:0], pix_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= 12'd640;
			height_q <= 13'd480;
			chans_q <= 3'd3;
			row_q <= '0;
			col_q <= '0;
			ir_q <= '0;
			ic_q <= '0;
			win_q <= '0;
			slots_q <= '0;
			cur_slot_q <= '0;
			iter_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_WIDTH:    width_q <= cfg_data[WCFG_W-1:0];
					REG_HEIGHT:   height_q <= cfg_data;
					REG_CHANNELS: chans_q <= cfg_data[NCFG_W-1:0];
					default: ;
				endcase
				if (cfg_index inside {REG_WIDTH, REG_HEIGHT, REG_CHANNELS}) begin
					row_q <= '0;
					col_q <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ir_q <= row_q;
						ic_q <= col_q;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= {pix_q, rd_q[31:0], rd_q[63:32]};
					slots_q[0] <= (ir_q != '0) && (ic_q != '0);
					slots_q[1] <= (ir_q != '0) && (ic_q != '0) && last_row;
					slots_q[2] <= (ir_q != '0) && last_col;
					slots_q[3] <= (ir_q != '0) && last_col && last_row;
					if ({1'b0, ic_q} + 12'd1 >= w) begin
						col_q <= '0;
						row_q <= ({1'b0, ir_q} + 13'd1 >= h) ? '0 : ir_q + 12'd1;
					end else begin
						col_q <= ic_q + 11'd1;
					end
					state_q <= S_PICK;
				end
				S_PICK: begin
					cur_slot_q <= pick;
					state_q <= (slots_q == '0) ? S_IDLE : S_LOAD;
				end
				S_LOAD: begin
					iter_q <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'(ROOT_STEPS - 1))
						state_q <= S_SUM;
				end
				S_SUM: state_q <= S_DIV;
				S_DIV: state_q <= S_OUT;
				S_OUT: begin
					if (out_acc) begin
						slots_q <= slots_q & ~cur_slot_q;
						state_q <= S_PICK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
		sem_lane u_lane (
			.clk (clk),
			.ctl (lctl),
			.nbr (nbr[k]),
			.mag (mag[k])
		);
	end

	sem_merge u_merge (
		.clk    (clk),
		.ctl    (mctl),
		.mag    (mag),
		.n      (n),
		.energy (energy)
	);

	`SEM_ASSERT_NEXT(a_accept_reads, in_acc, state_q == S_READ, "accept did not start read")
	`SEM_ASSERT_NOW(a_end_is_run_end, out_valid && image_end, run_end, "image end before run end")
	`SEM_ASSERT_NOW(a_one_slot, out_valid, $onehot(cur_slot_q) && ((slots_q & cur_slot_q) != 0),
		"result slot not pending")
endmodule

/* test/sobel_energy_map_core_tb.sv */
module sobel_energy_map_core_tb;
	import sem_pkg::*;

	typedef struct {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [MAG_W-1:0] energy;
		logic             run_end;
		logic             image_end;
	} energy_res_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  idx;
		int unsigned data;
		logic [31:0] pix;
		int          energy_typed; // -1: take the predicted energy
	} stim_row_t;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [7:0]        chan0 = 0, chan1 = 0, chan2 = 0, chan3 = 0;
	logic              out_valid;
	logic              out_stall = 0;
	logic [ROW_W-1:0]  pix_row;
	logic [COL_W-1:0]  pix_col;
	logic [MAG_W-1:0]  energy;
	logic              run_end;
	logic              image_end;
	logic              cfg_valid = 0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = 0;
	logic [HCFG_W-1:0] cfg_data = 0;

	sobel_energy_map_core i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// predictor state
	logic [WCFG_W-1:0] img_w_reg;
	logic [HCFG_W-1:0] img_h_reg;
	logic [NCFG_W-1:0] chan_reg;
	logic [31:0]       row_hist_old [MAX_WIDTH];
	logic [31:0]       row_hist_new [MAX_WIDTH];
	logic [31:0]       win [3][3]; // [column slot][row slot]
	int unsigned       pos_row, pos_col;

	energy_res_t pending_energy[$];
	bit          failed = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_req = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic int unsigned floor_sqrt(longint unsigned v);
		int unsigned res;
		longint unsigned trial;
		res = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = res | (1 << b);
			if (trial * trial <= v)
				res = trial;
		end
		return res;
	endfunction

	function automatic int px(int cs, int rs, int ch);
		return int'((win[cs][rs] >> (8 * ch)) & 32'hFF);
	endfunction

	function automatic int unsigned mean_grad(int l, int m, int r, int t, int c, int b,
						  int unsigned n);
		int gx, gy;
		int unsigned acc;
		acc = 0;
		for (int ch = 0; ch < n; ch++) begin
			gx = (px(r, t, ch) + 2 * px(r, c, ch) + px(r, b, ch))
			   - (px(l, t, ch) + 2 * px(l, c, ch) + px(l, b, ch));
			gy = (px(l, b, ch) + 2 * px(m, b, ch) + px(r, b, ch))
			   - (px(l, t, ch) + 2 * px(m, t, ch) + px(r, t, ch));
			acc += floor_sqrt(longint'(gx * gx + gy * gy) * 256);
		end
		return acc / n;
	endfunction

	function automatic void push_energy(int unsigned r, int unsigned c, int unsigned e,
					    bit last);
		energy_res_t x;
		x.row = r[ROW_W-1:0];
		x.col = c[COL_W-1:0];
		x.energy = e[MAG_W-1:0];
		x.run_end = 0;
		x.image_end = last;
		pending_energy.push_back(x);
	endfunction

	function automatic void apply_reg(logic [1:0] idx, int unsigned d);
		case (idx)
			REG_WIDTH:    img_w_reg = d[WCFG_W-1:0];
			REG_HEIGHT:   img_h_reg = d[HCFG_W-1:0];
			REG_CHANNELS: chan_reg  = d[NCFG_W-1:0];
			default:      return;
		endcase
		pos_row = 0;
		pos_col = 0;
	endfunction

	function automatic void predict_energies(logic [31:0] pix, int energy_typed);
		int unsigned w, h, n, r, c, first;
		int top, l;
		bit lastrow;
		w = clampu(img_w_reg, 2, MAX_WIDTH);
		h = clampu(img_h_reg, 2, MAX_HEIGHT);
		n = clampu(chan_reg, 1, MAX_CHANNELS);
		r = pos_row;
		c = pos_col;
		first = pending_energy.size();
		for (int k = 0; k < 3; k++) begin
			win[0][k] = win[1][k];
			win[1][k] = win[2][k];
		end
		win[2][0] = row_hist_old[c];
		win[2][1] = row_hist_new[c];
		win[2][2] = pix;
		row_hist_old[c] = row_hist_new[c];
		row_hist_new[c] = pix;
		if (r >= 1) begin
			top = (r == 1);
			lastrow = (r == h - 1);
			if (c >= 1) begin
				l = (c == 1);
				push_energy(r - 1, c - 1, mean_grad(l, 1, 2, top, 1, 2, n), 0);
				if (lastrow)
					push_energy(r, c - 1, mean_grad(l, 1, 2, 1, 2, 2, n), 0);
			end
			if (c == w - 1) begin
				push_energy(r - 1, c, mean_grad(1, 2, 2, top, 1, 2, n), 0);
				if (lastrow)
					push_energy(r, c, mean_grad(1, 2, 2, 1, 2, 2, n), 1);
			end
			if (pending_energy.size() > first)
				pending_energy[pending_energy.size() - 1].run_end = 1;
			if (energy_typed >= 0)
				for (int i = first; i < pending_energy.size(); i++)
					pending_energy[i].energy = energy_typed[MAG_W-1:0];
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		pos_row = r;
		pos_col = c;
	endfunction

	// valid stays high after the accept; the next call replaces the pixel or drops valid, or wait_idle drops it
	task automatic send_pixel(logic [31:0] pix, int energy_typed);
		cfg_valid <= 0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		{chan3, chan2, chan1, chan0} <= pix;
		do @(posedge clk); while (in_stall);
		predict_energies(pix, energy_typed);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= d[HCFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
	endtask

	// results drain, then let pixels that make no result leave the pipe
	task automatic wait_idle();
		in_valid <= 0;
		cfg_valid <= 0;
		while (pending_energy.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_pix();
		logic [31:0] p;
		for (int k = 0; k < 4; k++)
			case ($urandom_range(3))
				0: p[8*k +: 8] = 8'h00;
				1: p[8*k +: 8] = 8'hFF;
				default: p[8*k +: 8] = $urandom_range(255);
			endcase
		return p;
	endfunction

	task automatic stream_image(int unsigned limit);
		int unsigned total;
		total = clampu(img_w_reg, 2, MAX_WIDTH) * clampu(img_h_reg, 2, MAX_HEIGHT);
		if ($urandom_range(4) == 0)
			total = $urandom_range(1, total); // broken image, cut short
		if (total > limit)
			total = limit;
		for (int i = 0; i < total; i++)
			send_pixel(rand_pix(), -1);
	endtask

	// receiver stall, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		energy_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_energy.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d energy %0d", $time,
					 pix_row, pix_col, energy);
				failed = 1;
			end else begin
				e = pending_energy.pop_front();
				if (pix_row !== e.row) begin
					$display("%0t: pix_row exp %0d got %0d", $time, e.row, pix_row);
					failed = 1;
				end
				if (pix_col !== e.col) begin
					$display("%0t: pix_col exp %0d got %0d", $time, e.col, pix_col);
					failed = 1;
				end
				if (energy !== e.energy) begin
					$display("%0t: energy exp %0d got %0d", $time, e.energy, energy);
					failed = 1;
				end
				if (run_end !== e.run_end) begin
					$display("%0t: run_end exp %0d got %0d", $time, e.run_end, run_end);
					failed = 1;
				end
				if (image_end !== e.image_end) begin
					$display("%0t: image_end exp %0d got %0d", $time, e.image_end,
						 image_end);
					failed = 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 5000) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_energy.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	stim_row_t directed[] = '{
		'{1, REG_WIDTH,    2, 0, -1},
		'{1, REG_HEIGHT,   2, 0, -1},
		'{1, REG_CHANNELS, 4, 0, -1},
		// vertical step on all channels: gx = 1020 everywhere
		'{0, 0, 0, 32'h00000000, 16320},
		'{0, 0, 0, 32'hFFFFFFFF, 16320},
		'{0, 0, 0, 32'h00000000, 16320},
		'{0, 0, 0, 32'hFFFFFFFF, 16320},
		// zero channel count acts as one; channel 0, the only one used, is flat
		'{1, REG_CHANNELS, 0, 0, -1},
		'{0, 0, 0, 32'h00FF00FF, 0},
		'{0, 0, 0, 32'hFFFF00FF, 0},
		'{0, 0, 0, 32'h000000FF, 0},
		'{0, 0, 0, 32'hFF0000FF, 0},
		// out of range sizes and channel count, clamped
		'{1, REG_CHANNELS, 7, 0, -1},
		'{1, REG_WIDTH,    1, 0, -1},
		'{1, REG_HEIGHT,   0, 0, -1},
		'{0, 0, 0, 32'hFF00FF00, -1},
		'{0, 0, 0, 32'h00000000, -1},
		'{0, 0, 0, 32'h00FF00FF, -1},
		'{0, 0, 0, 32'hFFFFFFFF, -1},
		// unused index: no effect, counters keep going into the next image
		'{1, 2'd3, 5, 0, -1},
		'{0, 0, 0, 32'hFFFFFFFF, -1},
		'{0, 0, 0, 32'h00000000, -1},
		'{0, 0, 0, 32'h00000000, -1},
		'{0, 0, 0, 32'hFFFFFFFF, -1}
	};

	initial begin
		img_w_reg = 640;
		img_h_reg = 480;
		chan_reg  = 3;
		pos_row = 0;
		pos_col = 0;
		foreach (win[i, j])
			win[i][j] = 0;
		foreach (row_hist_old[i]) begin
			row_hist_old[i] = 0;
			row_hist_new[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i])
			if (directed[i].is_cfg) begin
				wait_idle();
				write_reg(directed[i].idx, directed[i].data);
			end else
				send_pixel(directed[i].pix, directed[i].energy_typed);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 49; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 49; end
				default: begin send_idle_pct = 13; stall_pct = 13; end
			endcase
			for (int img = 0; img < 5; img++) begin
				wait_idle();
				if ($urandom_range(1))
					write_reg(REG_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(4095)
									      : $urandom_range(2, 6));
				if ($urandom_range(1))
					write_reg(REG_HEIGHT, ($urandom_range(9) == 0) ? $urandom_range(8191)
										: $urandom_range(0, 5));
				if ($urandom_range(1))
					write_reg(REG_CHANNELS, $urandom_range(7));
				if ($urandom_range(5) == 0)
					write_reg(2'd3, $urandom_range(8191));
				stream_image(6);
			end
		end

		// widest setting, clamped to the maximum, first pixels only; then tallest setting
		send_idle_pct = 13;
		stall_pct = 13;
		wait_idle();
		write_reg(REG_WIDTH, 4095);
		write_reg(REG_HEIGHT, 2);
		write_reg(REG_CHANNELS, 4);
		for (int i = 0; i < 8; i++)
			send_pixel(rand_pix(), -1);
		wait_idle();
		write_reg(REG_WIDTH, 2);
		write_reg(REG_HEIGHT, 8191);
		// long receiver hold-off while pixels keep coming
		hold_req = 1;
		for (int i = 0; i < 24; i++)
			send_pixel(rand_pix(), -1);

		wait_idle();
		if (!failed)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
